@@ sv/dtse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtse_pkg
// Shared sizes, codes, types and the controller/datapath command set of the
// DAG topological sort engine.
// ----------------------------------------------------------------------------
package dtse_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int KEY_W        = 32;
    localparam int VID_W        = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int EIDX_W       = $clog2(MAX_EDGES);
    localparam int EPTR_W       = $clog2(MAX_EDGES + 1);

    localparam logic [EPTR_W-1:0] EDGE_END = EPTR_W'(MAX_EDGES);

    // Request kinds
    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_SORT = 2'd1;
    localparam logic [1:0] REQ_SUCC = 2'd2;
    localparam logic [1:0] REQ_LIST = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VFULL = 2'd1;
    localparam logic [1:0] ST_EFULL = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // Search colours
    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_GRAY  = 2'd1;
    localparam logic [1:0] COL_BLACK = 2'd2;

    typedef enum logic [5:0] {
        OP_NONE, OP_ACCEPT, OP_LK_RD, OP_LK_CMP, OP_AH_RD, OP_E_LOAD,
        OP_ED_RD, OP_E_NEXT, OP_INS_A, OP_INS_B, OP_LINK, OP_LINK_TAIL,
        OP_LINK_END, OP_EMIT_CODE, OP_SET_SORTED, OP_SORT_INIT, OP_CLR,
        OP_IDX_CLR, OP_IDX_INC, OP_VO_RD, OP_ROOT_COL, OP_ROOT_GRAY,
        OP_DS_SET, OP_FINISH, OP_POP, OP_DS_RD, OP_DS_T, OP_DS_PUSH,
        OP_FS_RD, OP_FS_WR, OP_VK_ORD, OP_EMIT_ORD, OP_VK_TGT, OP_EMIT_SUC
    } dp_op_t;

    typedef enum logic [5:0] {
        S_IDLE, S_LK_RD, S_LK_CMP, S_LK_DONE, S_DU_AH, S_DU_E, S_DU_CHK,
        S_DU_CMP, S_EF_CHK, S_INS_A, S_INS_B, S_LINK_RD, S_LINK,
        S_LINK_TAIL, S_LINK_END, S_EMIT_CODE, S_SU_AH, S_SU_E, S_SU_CHK,
        S_SU_ED, S_SU_VK, S_SU_EMIT, S_SORT_CHK, S_CLR, S_RT_RD, S_RT_COL,
        S_RT_CHK, S_RT_NEXT, S_DS_SET, S_DS, S_POP, S_DS_T, S_DS_C,
        S_CP_RD, S_CP_WR, S_LIST_CHK, S_EO_RD, S_EO_K, S_EO_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_req;
        logic [1:0] req;
        logic       scan_end;
        logic       last_emit;
        logic       empty;
        logic       a_found;
        logic       b_found;
        logic       v_full;
        logic       e_full;
        logic       e_end;
        logic       tgt_hit;
        logic       head_end;
        logic       nxt_end;
        logic       color_white;
        logic       top_end;
        logic       sp_one;
        logic       out_free;
    } sts_t;

endpackage

@@ sv/dtse_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtse_ctrl
// Request sequencer: walks lookup, insert, search, copy and emit phases and
// issues at most one datapath command per cycle, waiting on a busy output.
// ----------------------------------------------------------------------------
module dtse_ctrl
    import dtse_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;

    // State and pending status code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LK_RD;
                    if (sts.in_req == REQ_SORT) state_next = S_SORT_CHK;
                    if (sts.in_req == REQ_LIST) state_next = S_LIST_CHK;
                end
            end
            S_LK_RD:  state_next = sts.scan_end ? S_LK_DONE : S_LK_CMP;
            S_LK_CMP: state_next = S_LK_RD;
            S_LK_DONE: begin
                if (sts.req == REQ_SUCC) begin
                    if (sts.a_found) begin
                        state_next = S_SU_AH;
                    end else begin
                        code_next  = ST_NONE;
                        state_next = S_EMIT_CODE;
                    end
                end else if (sts.v_full) begin
                    code_next  = ST_VFULL;
                    state_next = S_EMIT_CODE;
                end else if (sts.a_found && sts.b_found) begin
                    state_next = S_DU_AH;
                end else begin
                    state_next = S_EF_CHK;
                end
            end
            S_DU_AH:  state_next = S_DU_E;
            S_DU_E:   state_next = S_DU_CHK;
            S_DU_CHK: state_next = sts.e_end ? S_EF_CHK : S_DU_CMP;
            S_DU_CMP: begin
                if (sts.tgt_hit) begin
                    code_next  = ST_OK;
                    state_next = S_EMIT_CODE;
                end else begin
                    state_next = S_DU_CHK;
                end
            end
            S_EF_CHK: begin
                if (sts.e_full) begin
                    code_next  = ST_EFULL;
                    state_next = S_EMIT_CODE;
                end else begin
                    state_next = S_INS_A;
                end
            end
            S_INS_A:     state_next = S_INS_B;
            S_INS_B:     state_next = S_LINK_RD;
            S_LINK_RD:   state_next = S_LINK;
            S_LINK:      state_next = sts.head_end ? S_LINK_END : S_LINK_TAIL;
            S_LINK_TAIL: state_next = S_LINK_END;
            S_LINK_END: begin
                code_next  = ST_OK;
                state_next = S_EMIT_CODE;
            end
            S_EMIT_CODE: if (sts.out_free) state_next = S_IDLE;
            S_SU_AH: state_next = S_SU_E;
            S_SU_E:  state_next = S_SU_CHK;
            S_SU_CHK: begin
                if (sts.e_end) begin
                    code_next  = ST_NONE;
                    state_next = S_EMIT_CODE;
                end else begin
                    state_next = S_SU_ED;
                end
            end
            S_SU_ED: state_next = S_SU_VK;
            S_SU_VK: state_next = S_SU_EMIT;
            S_SU_EMIT: begin
                if (sts.out_free) state_next = sts.nxt_end ? S_IDLE : S_SU_ED;
            end
            S_SORT_CHK: begin
                if (sts.empty) begin
                    code_next  = ST_NONE;
                    state_next = S_EMIT_CODE;
                end else begin
                    state_next = S_CLR;
                end
            end
            S_CLR:     state_next = sts.scan_end ? S_RT_RD : S_CLR;
            S_RT_RD:   state_next = sts.scan_end ? S_CP_RD : S_RT_COL;
            S_RT_COL:  state_next = S_RT_CHK;
            S_RT_CHK:  state_next = sts.color_white ? S_DS_SET : S_RT_RD;
            S_RT_NEXT: state_next = S_RT_RD;
            S_DS_SET:  state_next = S_DS;
            S_DS: begin
                if (sts.top_end) state_next = sts.sp_one ? S_RT_NEXT : S_POP;
                else             state_next = S_DS_T;
            end
            S_POP:     state_next = S_DS;
            S_DS_T:    state_next = S_DS_C;
            S_DS_C:    state_next = sts.color_white ? S_DS_SET : S_DS;
            S_CP_RD:   state_next = sts.scan_end ? S_LIST_CHK : S_CP_WR;
            S_CP_WR:   state_next = S_CP_RD;
            S_LIST_CHK: begin
                if (sts.empty) begin
                    code_next  = ST_NONE;
                    state_next = S_EMIT_CODE;
                end else begin
                    state_next = S_EO_RD;
                end
            end
            S_EO_RD: state_next = S_EO_K;
            S_EO_K:  state_next = S_EO_EMIT;
            S_EO_EMIT: begin
                if (sts.out_free) state_next = sts.last_emit ? S_IDLE : S_EO_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd.op   = OP_NONE;
        cmd.code = code_reg;
        s_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_ACCEPT;
            end
            S_LK_RD:     if (!sts.scan_end) cmd.op = OP_LK_RD;
            S_LK_CMP:    cmd.op = OP_LK_CMP;
            S_DU_AH:     cmd.op = OP_AH_RD;
            S_DU_E:      cmd.op = OP_E_LOAD;
            S_DU_CHK:    if (!sts.e_end) cmd.op = OP_ED_RD;
            S_DU_CMP:    if (!sts.tgt_hit) cmd.op = OP_E_NEXT;
            S_INS_A:     cmd.op = OP_INS_A;
            S_INS_B:     cmd.op = OP_INS_B;
            S_LINK_RD:   cmd.op = OP_AH_RD;
            S_LINK:      cmd.op = OP_LINK;
            S_LINK_TAIL: cmd.op = OP_LINK_TAIL;
            S_LINK_END:  cmd.op = OP_LINK_END;
            S_EMIT_CODE: if (sts.out_free) cmd.op = OP_EMIT_CODE;
            S_SU_AH:     cmd.op = OP_AH_RD;
            S_SU_E:      cmd.op = OP_E_LOAD;
            S_SU_ED:     cmd.op = OP_ED_RD;
            S_SU_VK:     cmd.op = OP_VK_TGT;
            S_SU_EMIT:   if (sts.out_free) cmd.op = OP_EMIT_SUC;
            S_SORT_CHK:  cmd.op = sts.empty ? OP_SET_SORTED : OP_SORT_INIT;
            S_CLR:       cmd.op = sts.scan_end ? OP_IDX_CLR : OP_CLR;
            S_RT_RD:     cmd.op = sts.scan_end ? OP_IDX_CLR : OP_VO_RD;
            S_RT_COL:    cmd.op = OP_ROOT_COL;
            S_RT_CHK:    cmd.op = sts.color_white ? OP_ROOT_GRAY : OP_IDX_INC;
            S_RT_NEXT:   cmd.op = OP_IDX_INC;
            S_DS_SET:    cmd.op = OP_DS_SET;
            S_DS:        cmd.op = sts.top_end ? OP_FINISH : OP_DS_RD;
            S_POP:       cmd.op = OP_POP;
            S_DS_T:      cmd.op = OP_DS_T;
            S_DS_C:      if (sts.color_white) cmd.op = OP_DS_PUSH;
            S_CP_RD:     cmd.op = sts.scan_end ? OP_SET_SORTED : OP_FS_RD;
            S_CP_WR:     cmd.op = OP_FS_WR;
            S_LIST_CHK:  if (!sts.empty) cmd.op = OP_IDX_CLR;
            S_EO_RD:     cmd.op = OP_VO_RD;
            S_EO_K:      cmd.op = OP_VK_ORD;
            S_EO_EMIT:   if (sts.out_free) cmd.op = OP_EMIT_ORD;
            default:     cmd.op = OP_NONE;
        endcase
    end

    // Checks
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT_CODE || cmd.op == OP_EMIT_ORD || cmd.op == OP_EMIT_SUC)
        |-> sts.out_free)
        else $error("emit into busy output");
    a_accept_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != S_IDLE)
        else $error("accepted transaction left idle");

endmodule

@@ sv/dtse_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtse_dp
// Datapath: vertex, adjacency, edge, colour and stack memories, counters and
// the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
module dtse_dp
    import dtse_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [1:0]       s_req_type,
    input  logic [KEY_W-1:0] s_first_key,
    input  logic [KEY_W-1:0] s_second_key,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_key_out,
    output logic             m_last_item,
    output logic [1:0]       m_status,
    output logic             m_sorted_flag
);

    // Memories
    logic [KEY_W-1:0]  vk_mem [MAX_VERTICES];
    logic [VID_W-1:0]  vo_mem [MAX_VERTICES];
    logic [EPTR_W-1:0] ah_mem [MAX_VERTICES];
    logic [EPTR_W-1:0] at_mem [MAX_VERTICES];
    logic [1:0]        col_mem [MAX_VERTICES];
    logic [VID_W+EPTR_W-1:0] ss_mem [MAX_VERTICES];
    logic [VID_W-1:0]  fs_mem [MAX_VERTICES];
    logic [VID_W-1:0]  et_mem [MAX_EDGES];
    logic [EPTR_W-1:0] en_mem [MAX_EDGES];

    logic [KEY_W-1:0]  vk_q;
    logic [VID_W-1:0]  vo_q, et_q, fs_q;
    logic [EPTR_W-1:0] ah_q, at_q, en_q;
    logic [1:0]        col_q;
    logic [VID_W+EPTR_W-1:0] ss_q;

    // Memory port controls
    logic vk_re, vo_re, ah_re, col_re, ss_re, fs_re, ed_re;
    logic vk_we, vo_we, ah_we, at_we, col_we, ss_we, fs_we, et_we, en_we;
    logic [VID_W-1:0]  vk_ra, vo_ra, ah_ra, col_ra, ss_ra, fs_ra;
    logic [VID_W-1:0]  vk_wa, vo_wa, ah_wa, at_wa, col_wa, ss_wa, fs_wa;
    logic [EIDX_W-1:0] ed_ra, et_wa, en_wa;
    logic [KEY_W-1:0]  vk_wd;
    logic [VID_W-1:0]  vo_wd, et_wd, fs_wd;
    logic [EPTR_W-1:0] ah_wd, at_wd, en_wd;
    logic [1:0]        col_wd;
    logic [VID_W+EPTR_W-1:0] ss_wd;

    // Control registers
    logic [VCNT_W-1:0] vcnt_reg, vcnt_next, idx_reg, idx_next;
    logic [VCNT_W-1:0] sp_reg, sp_next, fc_reg, fc_next;
    logic [EPTR_W-1:0] ecnt_reg, ecnt_next;
    logic              smark_reg, smark_next, mv_reg, mv_next;

    // Payload registers
    logic [1:0]        req_reg, req_next;
    logic [KEY_W-1:0]  ka_reg, ka_next, kb_reg, kb_next;
    logic              af_reg, af_next, bf_reg, bf_next;
    logic [VID_W-1:0]  a_reg, a_next, b_reg, b_next, t_reg, t_next;
    logic [VID_W-1:0]  tv_reg, tv_next;
    logic [EPTR_W-1:0] te_reg, te_next, e_reg, e_next;
    logic [KEY_W-1:0]  mk_reg, mk_next;
    logic              ml_reg, ml_next, ms_reg, ms_next;
    logic [1:0]        mst_reg, mst_next;

    logic              out_free;
    logic [VCNT_W:0]   need;

    assign out_free = !mv_reg || m_ready;
    assign need = (VCNT_W+1)'(!af_reg) + (VCNT_W+1)'(!bf_reg && (ka_reg != kb_reg));

    // Status to the controller
    always_comb begin
        sts.in_req      = s_req_type;
        sts.req         = req_reg;
        sts.scan_end    = idx_reg == vcnt_reg;
        sts.last_emit   = (idx_reg + VCNT_W'(1)) == vcnt_reg;
        sts.empty       = vcnt_reg == '0;
        sts.a_found     = af_reg;
        sts.b_found     = bf_reg;
        sts.v_full      = ({1'b0, vcnt_reg} + need) > (VCNT_W+1)'(MAX_VERTICES);
        sts.e_full      = ecnt_reg >= EDGE_END;
        sts.e_end       = e_reg >= EDGE_END;
        sts.tgt_hit     = et_q == b_reg;
        sts.head_end    = ah_q >= EDGE_END;
        sts.nxt_end     = en_q >= EDGE_END;
        sts.color_white = col_q == COL_WHITE;
        sts.top_end     = te_reg >= EDGE_END;
        sts.sp_one      = sp_reg == VCNT_W'(1);
        sts.out_free    = out_free;
    end

    // Command decode
    always_comb begin
        vcnt_next = vcnt_reg;  idx_next = idx_reg;  sp_next = sp_reg;
        fc_next = fc_reg;  ecnt_next = ecnt_reg;  smark_next = smark_reg;
        req_next = req_reg;  ka_next = ka_reg;  kb_next = kb_reg;
        af_next = af_reg;  bf_next = bf_reg;  a_next = a_reg;  b_next = b_reg;
        t_next = t_reg;  tv_next = tv_reg;  te_next = te_reg;  e_next = e_reg;
        mk_next = mk_reg;  ml_next = ml_reg;  ms_next = ms_reg;
        mst_next = mst_reg;
        mv_next = mv_reg && !m_ready;

        vk_re = 1'b0; vo_re = 1'b0; ah_re = 1'b0; col_re = 1'b0;
        ss_re = 1'b0; fs_re = 1'b0; ed_re = 1'b0;
        vk_we = 1'b0; vo_we = 1'b0; ah_we = 1'b0; at_we = 1'b0;
        col_we = 1'b0; ss_we = 1'b0; fs_we = 1'b0; et_we = 1'b0; en_we = 1'b0;
        vk_ra = idx_reg[VID_W-1:0];  vo_ra = idx_reg[VID_W-1:0];
        ah_ra = a_reg;  col_ra = vo_q;  ss_ra = VID_W'(sp_reg - VCNT_W'(2));
        fs_ra = VID_W'(fc_reg - VCNT_W'(1) - idx_reg);
        ed_ra = e_reg[EIDX_W-1:0];
        vk_wa = vcnt_reg[VID_W-1:0];  vo_wa = vcnt_reg[VID_W-1:0];
        ah_wa = vcnt_reg[VID_W-1:0];  at_wa = vcnt_reg[VID_W-1:0];
        col_wa = idx_reg[VID_W-1:0];  ss_wa = VID_W'(sp_reg - VCNT_W'(1));
        fs_wa = fc_reg[VID_W-1:0];
        et_wa = ecnt_reg[EIDX_W-1:0];  en_wa = ecnt_reg[EIDX_W-1:0];
        vk_wd = ka_reg;  vo_wd = vcnt_reg[VID_W-1:0];
        ah_wd = EDGE_END;  at_wd = EDGE_END;  col_wd = COL_WHITE;
        ss_wd = {tv_reg, te_reg};  fs_wd = tv_reg;  et_wd = b_reg;
        en_wd = EDGE_END;

        case (cmd.op)
            OP_ACCEPT: begin
                req_next = s_req_type;  ka_next = s_first_key;
                kb_next = s_second_key;  af_next = 1'b0;  bf_next = 1'b0;
                idx_next = '0;
            end
            OP_LK_RD: vk_re = 1'b1;
            // Compare one stored key against both request keys
            OP_LK_CMP: begin
                if (!af_reg && vk_q == ka_reg) begin
                    af_next = 1'b1;  a_next = idx_reg[VID_W-1:0];
                end
                if (!bf_reg && vk_q == kb_reg) begin
                    bf_next = 1'b1;  b_next = idx_reg[VID_W-1:0];
                end
                idx_next = idx_reg + VCNT_W'(1);
            end
            OP_AH_RD:  ah_re = 1'b1;
            OP_E_LOAD: e_next = ah_q;
            OP_ED_RD:  ed_re = 1'b1;
            OP_E_NEXT: e_next = en_q;
            OP_INS_A: begin
                if (!af_reg) begin
                    vk_we = 1'b1; vo_we = 1'b1; ah_we = 1'b1; at_we = 1'b1;
                    a_next = vcnt_reg[VID_W-1:0];  af_next = 1'b1;
                    vcnt_next = vcnt_reg + VCNT_W'(1);
                end
            end
            OP_INS_B: begin
                if (!bf_reg) begin
                    bf_next = 1'b1;
                    if (ka_reg == kb_reg) begin
                        b_next = a_reg;
                    end else begin
                        vk_we = 1'b1; vo_we = 1'b1; ah_we = 1'b1; at_we = 1'b1;
                        vk_wd = kb_reg;  b_next = vcnt_reg[VID_W-1:0];
                        vcnt_next = vcnt_reg + VCNT_W'(1);
                    end
                end
            end
            // Append the edge record and hook it into the source's list
            OP_LINK: begin
                et_we = 1'b1;  en_we = 1'b1;  at_we = 1'b1;
                at_wa = a_reg;  at_wd = ecnt_reg;
                ah_wa = a_reg;  ah_wd = ecnt_reg;
                ah_we = ah_q >= EDGE_END;
            end
            OP_LINK_TAIL: begin
                en_we = 1'b1;  en_wa = at_q[EIDX_W-1:0];  en_wd = ecnt_reg;
            end
            OP_LINK_END: begin
                ecnt_next = ecnt_reg + EPTR_W'(1);  smark_next = 1'b0;
            end
            OP_EMIT_CODE: begin
                mv_next = 1'b1;  mk_next = '0;  ml_next = 1'b1;
                mst_next = cmd.code;  ms_next = smark_reg;
            end
            OP_SET_SORTED: smark_next = 1'b1;
            OP_SORT_INIT: begin
                idx_next = '0;  fc_next = '0;  sp_next = '0;
            end
            OP_CLR: begin
                col_we = 1'b1;  idx_next = idx_reg + VCNT_W'(1);
            end
            OP_IDX_CLR: idx_next = '0;
            OP_IDX_INC: idx_next = idx_reg + VCNT_W'(1);
            OP_VO_RD:   vo_re = 1'b1;
            OP_ROOT_COL: begin
                t_next = vo_q;  col_re = 1'b1;
            end
            OP_ROOT_GRAY: begin
                col_we = 1'b1;  col_wa = t_reg;  col_wd = COL_GRAY;
                ah_re = 1'b1;  ah_ra = t_reg;
            end
            OP_DS_SET: begin
                tv_next = t_reg;  te_next = ah_q;  sp_next = sp_reg + VCNT_W'(1);
            end
            // Retire the top vertex and fetch the one beneath it
            OP_FINISH: begin
                col_we = 1'b1;  col_wa = tv_reg;  col_wd = COL_BLACK;
                fs_we = 1'b1;  fc_next = fc_reg + VCNT_W'(1);
                sp_next = sp_reg - VCNT_W'(1);  ss_re = 1'b1;
            end
            OP_POP: begin
                tv_next = ss_q[VID_W+EPTR_W-1:EPTR_W];
                te_next = ss_q[EPTR_W-1:0];
            end
            OP_DS_RD: begin
                ed_re = 1'b1;  ed_ra = te_reg[EIDX_W-1:0];
            end
            OP_DS_T: begin
                t_next = et_q;  te_next = en_q;  col_re = 1'b1;  col_ra = et_q;
            end
            OP_DS_PUSH: begin
                col_we = 1'b1;  col_wa = t_reg;  col_wd = COL_GRAY;
                ss_we = 1'b1;  ah_re = 1'b1;  ah_ra = t_reg;
            end
            OP_FS_RD: fs_re = 1'b1;
            OP_FS_WR: begin
                vo_we = 1'b1;  vo_wa = idx_reg[VID_W-1:0];  vo_wd = fs_q;
                idx_next = idx_reg + VCNT_W'(1);
            end
            OP_VK_ORD: begin
                vk_re = 1'b1;  vk_ra = vo_q;
            end
            OP_EMIT_ORD: begin
                mv_next = 1'b1;  mk_next = vk_q;
                ml_next = (idx_reg + VCNT_W'(1)) == vcnt_reg;
                mst_next = ST_OK;  ms_next = smark_reg;
                idx_next = idx_reg + VCNT_W'(1);
            end
            OP_VK_TGT: begin
                vk_re = 1'b1;  vk_ra = et_q;
            end
            OP_EMIT_SUC: begin
                mv_next = 1'b1;  mk_next = vk_q;  ml_next = en_q >= EDGE_END;
                mst_next = ST_OK;  ms_next = smark_reg;  e_next = en_q;
            end
            default: ;
        endcase
    end

    // Memory ports
    always_ff @(posedge aclk) begin
        if (vk_we)  vk_mem[vk_wa] <= vk_wd;
        if (vk_re)  vk_q <= vk_mem[vk_ra];
        if (vo_we)  vo_mem[vo_wa] <= vo_wd;
        if (vo_re)  vo_q <= vo_mem[vo_ra];
        if (ah_we)  ah_mem[ah_wa] <= ah_wd;
        if (at_we)  at_mem[at_wa] <= at_wd;
        if (ah_re) begin
            ah_q <= ah_mem[ah_ra];
            at_q <= at_mem[ah_ra];
        end
        if (col_we) col_mem[col_wa] <= col_wd;
        if (col_re) col_q <= col_mem[col_ra];
        if (ss_we)  ss_mem[ss_wa] <= ss_wd;
        if (ss_re)  ss_q <= ss_mem[ss_ra];
        if (fs_we)  fs_mem[fs_wa] <= fs_wd;
        if (fs_re)  fs_q <= fs_mem[fs_ra];
        if (et_we)  et_mem[et_wa] <= et_wd;
        if (en_we)  en_mem[en_wa] <= en_wd;
        if (ed_re) begin
            et_q <= et_mem[ed_ra];
            en_q <= en_mem[ed_ra];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg <= '0;  idx_reg <= '0;  sp_reg <= '0;  fc_reg <= '0;
            ecnt_reg <= '0;  smark_reg <= 1'b0;  mv_reg <= 1'b0;
        end else begin
            vcnt_reg <= vcnt_next;  idx_reg <= idx_next;  sp_reg <= sp_next;
            fc_reg <= fc_next;  ecnt_reg <= ecnt_next;
            smark_reg <= smark_next;  mv_reg <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg <= req_next;  ka_reg <= ka_next;  kb_reg <= kb_next;
        af_reg <= af_next;  bf_reg <= bf_next;  a_reg <= a_next;
        b_reg <= b_next;  t_reg <= t_next;  tv_reg <= tv_next;
        te_reg <= te_next;  e_reg <= e_next;  mk_reg <= mk_next;
        ml_reg <= ml_next;  ms_reg <= ms_next;  mst_reg <= mst_next;
    end

    assign m_valid       = mv_reg;
    assign m_key_out     = mk_reg;
    assign m_last_item   = ml_reg;
    assign m_status      = mst_reg;
    assign m_sorted_flag = ms_reg;

    // Checks
    a_vcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcnt_reg <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count overflow");
    a_ecnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ecnt_reg <= EPTR_W'(MAX_EDGES))
        else $error("edge count overflow");
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= vcnt_reg && fc_reg <= vcnt_reg)
        else $error("search or finish stack beyond vertex count");

endmodule

@@ sv/dag_topological_sort_engine_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one request at a time, accepted only when idle; a sort clears
//   colours, searches, copies and emits, and the single-port tables are walked
//   one entry at a time. Each result is read from the order or edge table and
//   then the key table before it leaves, stalling while the output is busy.
// Reset: synchronous, active low; clears counters and sorted mark, no sweep.
// ----------------------------------------------------------------------------
// dag_topological_sort_engine_unit
// Top level: graph store with depth-first topological sort, joining the
// request sequencer and the table datapath.
// ----------------------------------------------------------------------------
module dag_topological_sort_engine_unit
    import dtse_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [KEY_W-1:0] s_first_key,
    input  logic [KEY_W-1:0] s_second_key,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [KEY_W-1:0] m_key_out,
    output logic             m_last_item,
    output logic [1:0]       m_status,
    output logic             m_sorted_flag
);

    cmd_t cmd;
    sts_t sts;

    dtse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dtse_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_req_type    (s_req_type),
        .s_first_key   (s_first_key),
        .s_second_key  (s_second_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_out     (m_key_out),
        .m_last_item   (m_last_item),
        .m_status      (m_status),
        .m_sorted_flag (m_sorted_flag)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph sort engine testbench
// Drives add-edge, sort, successor and list requests through the valid/ready
// input channel, predicts every result burst with a behavioural graph store
// and checks each result transaction field by field, under random idling and
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb;
    import dtse_pkg::*;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             last;
        logic [1:0]       st;
        logic             flag;
    } burst_item_t;

    // Graph store predictor and result checker
    class graph_scoreboard;
        logic [KEY_W-1:0] vkey [MAX_VERTICES];
        int               vorder [MAX_VERTICES];
        int               vcount;
        int               head [MAX_VERTICES];
        int               tail [MAX_VERTICES];
        int               etgt [MAX_EDGES];
        int               enext [MAX_EDGES];
        int               ecount;
        logic             sorted;
        burst_item_t      burst_q [$];
        int               errors;

        function new();
            vcount = 0;
            ecount = 0;
            sorted = 1'b0;
            errors = 0;
        endfunction

        function void push(logic [KEY_W-1:0] key, logic last, logic [1:0] st);
            burst_item_t it;
            it.key  = key;
            it.last = last;
            it.st   = st;
            it.flag = sorted;
            burst_q = {burst_q, it};
        endfunction

        function int lookup(logic [KEY_W-1:0] key);
            for (int i = 0; i < vcount; i++)
                if (vkey[i] == key)
                    return i;
            return -1;
        endfunction

        function int insert(logic [KEY_W-1:0] key);
            vkey[vcount]   = key;
            vorder[vcount] = vcount;
            head[vcount]   = MAX_EDGES;
            tail[vcount]   = MAX_EDGES;
            vcount++;
            return vcount - 1;
        endfunction

        function void add_edge(logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
            int a;
            int b;
            int need;
            a    = lookup(ka);
            b    = lookup(kb);
            need = (a < 0) + ((b < 0) && (kb != ka));
            if (vcount + need > MAX_VERTICES) begin
                push('0, 1'b1, ST_VFULL);
                return;
            end
            if (a >= 0 && b >= 0) begin
                for (int e = head[a]; e < MAX_EDGES; e = enext[e])
                    if (etgt[e] == b) begin
                        push('0, 1'b1, ST_OK);
                        return;
                    end
            end
            if (ecount >= MAX_EDGES) begin
                push('0, 1'b1, ST_EFULL);
                return;
            end
            if (a < 0)
                a = insert(ka);
            if (b < 0)
                b = (kb == ka) ? a : insert(kb);
            etgt[ecount]  = b;
            enext[ecount] = MAX_EDGES;
            if (head[a] >= MAX_EDGES)
                head[a] = ecount;
            else
                enext[tail[a]] = ecount;
            tail[a] = ecount;
            ecount++;
            sorted = 1'b0;
            push('0, 1'b1, ST_OK);
        endfunction

        function void emit_list();
            if (vcount == 0) begin
                push('0, 1'b1, ST_NONE);
                return;
            end
            for (int i = 0; i < vcount; i++)
                push(vkey[vorder[i]], i + 1 == vcount, ST_OK);
        endfunction

        // Depth-first search with an explicit stack, then reverse finish order
        function void sort_graph();
            int colour [MAX_VERTICES];
            int stk_v [MAX_VERTICES];
            int stk_e [MAX_VERTICES];
            int fin [MAX_VERTICES];
            int fc;
            int sp;
            int e;
            int t;
            fc = 0;
            foreach (colour[i])
                colour[i] = COL_WHITE;
            for (int i = 0; i < vcount; i++) begin
                if (colour[vorder[i]] != COL_WHITE)
                    continue;
                colour[vorder[i]] = COL_GRAY;
                stk_v[0] = vorder[i];
                stk_e[0] = head[vorder[i]];
                sp = 1;
                while (sp > 0) begin
                    e = stk_e[sp-1];
                    if (e >= MAX_EDGES) begin
                        colour[stk_v[sp-1]] = COL_BLACK;
                        if (fc < MAX_VERTICES) begin
                            fin[fc] = stk_v[sp-1];
                            fc++;
                        end
                        sp--;
                    end else begin
                        t = etgt[e];
                        stk_e[sp-1] = enext[e];
                        if (colour[t] == COL_WHITE && sp < MAX_VERTICES) begin
                            colour[t] = COL_GRAY;
                            stk_v[sp] = t;
                            stk_e[sp] = head[t];
                            sp++;
                        end
                    end
                end
            end
            for (int i = 0; i < fc; i++)
                vorder[i] = fin[fc-1-i];
            sorted = 1'b1;
            emit_list();
        endfunction

        function void list_successors(logic [KEY_W-1:0] key);
            int a;
            a = lookup(key);
            if (a < 0 || head[a] >= MAX_EDGES) begin
                push('0, 1'b1, ST_NONE);
                return;
            end
            for (int e = head[a]; e < MAX_EDGES; e = enext[e])
                push(vkey[etgt[e]], enext[e] >= MAX_EDGES, ST_OK);
        endfunction

        // Note an accepted request transaction
        function void note_request(logic [1:0] req, logic [KEY_W-1:0] ka,
                                   logic [KEY_W-1:0] kb);
            case (req)
                REQ_ADD:  add_edge(ka, kb);
                REQ_SORT: sort_graph();
                REQ_SUCC: list_successors(ka);
                default:  emit_list();
            endcase
        endfunction

        // Compare a result transaction with the oldest expected item
        function void check_result(logic [KEY_W-1:0] key, logic last, logic [1:0] st,
                                   logic flag);
            burst_item_t x;
            if (burst_q.size() == 0) begin
                $error("unexpected result: key_out %h", key);
                errors++;
                return;
            end
            x = burst_q.pop_front();
            if (key !== x.key) begin
                $error("key_out: expected %h, actual %h", x.key, key);
                errors++;
            end
            if (last !== x.last) begin
                $error("last_item: expected %b, actual %b", x.last, last);
                errors++;
            end
            if (st !== x.st) begin
                $error("status: expected %0d, actual %0d", x.st, st);
                errors++;
            end
            if (flag !== x.flag) begin
                $error("sorted_flag: expected %b, actual %b", x.flag, flag);
                errors++;
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_req_type = REQ_LIST;
    logic [KEY_W-1:0] s_first_key = '0;
    logic [KEY_W-1:0] s_second_key = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [KEY_W-1:0] m_key_out;
    logic             m_last_item;
    logic [1:0]       m_status;
    logic             m_sorted_flag;

    graph_scoreboard  graph_sb = new();
    logic [KEY_W-1:0] key_pool [70];
    int               hold_asked = 0;
    int               hold_served = 0;
    int               hold_left = 0;
    longint           cycle_cnt = 0;

    dag_topological_sort_engine_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_first_key   (s_first_key),
        .s_second_key  (s_second_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_out     (m_key_out),
        .m_last_item   (m_last_item),
        .m_status      (m_status),
        .m_sorted_flag (m_sorted_flag)
    );

    always #5 aclk = ~aclk;

    // Abort on a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 20000000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Check results and randomise result back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            graph_sb.check_result(m_key_out, m_last_item, m_status, m_sorted_flag);
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if ((cycle_cnt / 400) % 3 == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= (pick_gap() == 0);
        end
    end

    // Offer one request transaction and hold it until accepted
    task automatic send(logic [1:0] req, logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_first_key  <= ka;
        s_second_key <= kb;
        do @(posedge aclk); while (!s_ready);
        graph_sb.note_request(req, ka, kb);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (graph_sb.burst_q.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, 69)];
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return REQ_ADD;
        if (r < 80)
            return REQ_SORT;
        if (r < 90)
            return REQ_SUCC;
        return REQ_LIST;
    endfunction

    initial begin
        int tries;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 70; i++)
            key_pool[i] = $urandom;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty graph, unknown key, duplicates, self edge, cycle
        send(REQ_LIST, '0, '0);
        send(REQ_SORT, '1, '1);
        send(REQ_SUCC, '0, '0);
        send(REQ_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        send(REQ_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        send(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        send(REQ_ADD, 32'hAAAA_AAAA, 32'h5555_5555);
        send(REQ_SUCC, 32'hFFFF_FFFF, '0);
        send(REQ_SUCC, 32'h5555_5555, '1);
        send(REQ_LIST, '1, '0);
        send(REQ_SORT, '0, '0);
        send(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
        send(REQ_LIST, '0, '1);
        send(REQ_SUCC, 32'h0000_0000, '0);
        send(REQ_ADD, 32'h0000_0000, 32'h1234_5678);
        send(REQ_SORT, '0, '0);
        send(REQ_LIST, '0, '0);

        // Random mix; one long result stall and one full drain on the way
        for (int n = 0; n < 100; n++) begin
            if (n == 30)
                hold_asked++;
            if (n == 70)
                drain();
            send(pick_req(), pick_key(), pick_key());
        end

        // Fill the edge table among known vertices, then push past both limits
        tries = 0;
        while (graph_sb.ecount < MAX_EDGES && tries < 6000) begin
            send(REQ_ADD, graph_sb.vkey[$urandom_range(0, graph_sb.vcount - 1)],
                 graph_sb.vkey[$urandom_range(0, graph_sb.vcount - 1)]);
            tries++;
        end
        send(REQ_ADD, graph_sb.vkey[0], graph_sb.vkey[1]);
        send(REQ_ADD, graph_sb.vkey[2], $urandom);
        send(REQ_ADD, $urandom, $urandom);
        send(REQ_SORT, '0, '0);
        send(REQ_SUCC, graph_sb.vkey[0], '0);
        send(REQ_LIST, '0, '0);

        drain();
        repeat (200) @(posedge aclk);
        if (graph_sb.errors == 0 && graph_sb.burst_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
